FILE: design/bcps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcps_pkg
// Shared types, register codes and helpers of the pump scheduler core.
// ----------------------------------------------------------------------------
package bcps_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int TIME_W      = 32;
   localparam int TDATA_W     = 8;

   // Register reset values
   localparam logic [31:0] WATERING_INTERVAL_RST = 32'd172800000;
   localparam logic [31:0] PUMP_DURATION_RST     = 32'd9000;
   localparam logic [15:0] LONG_PRESS_TIME_RST   = 16'd3000;
   localparam logic [15:0] PRESS_LOCKOUT_RST     = 16'd1000;
   localparam logic [7:0]  SAMPLE_PERIOD_RST     = 8'd20;
   localparam logic [31:0] BLINK_PERIOD_RST      = 32'd30000;
   localparam logic [15:0] BLINK_LENGTH_RST      = 16'd1000;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WATERING_INTERVAL = 3'd0,
      REG_PUMP_DURATION     = 3'd1,
      REG_LONG_PRESS_TIME   = 3'd2,
      REG_PRESS_LOCKOUT     = 3'd3,
      REG_SAMPLE_PERIOD     = 3'd4,
      REG_BLINK_PERIOD      = 3'd5,
      REG_BLINK_LENGTH      = 3'd6
   } reg_index_type;

   // Button event codes
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2
   } press_event_type;

   typedef struct packed {
      logic [31:0] watering_interval;
      logic [31:0] pump_duration;
      logic [15:0] long_press_time;
      logic [15:0] press_lockout;
      logic [7:0]  sample_period;
      logic [31:0] blink_period;
      logic [15:0] blink_length;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] last_sample_time;
      logic [TIME_W-1:0] press_start_time;
      logic [TIME_W-1:0] lockout_start_time;
      logic [TIME_W-1:0] interval_start_time;
      logic [TIME_W-1:0] pump_start_time;
      logic [TIME_W-1:0] blink_cycle_time;
      logic [TIME_W-1:0] blink_on_time;
      logic              auto_mode;
      logic              pump_on;
      logic              timed;
      logic              led_on;
   } state_type;

   typedef struct packed {
      press_event_type press_event;
      logic            auto_mode;
      logic            led_on;
      logic            pump_on;
   } result_type;

   // Wrapping elapsed-time test: (now - mark) mod 2^32 >= span
   function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] mark,
                                    input logic [TIME_W-1:0] span);
      logic [TIME_W-1:0] diff;
      diff = now - mark;
      return diff >= span;
   endfunction

endpackage : bcps_pkg
`default_nettype wire

FILE: design/bcps_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcps_csr
// Configuration register bank, written through the index/data channel.
// ----------------------------------------------------------------------------
module bcps_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [bcps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bcps_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output      bcps_pkg::cfg_type                  cfg
);
   import bcps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always ready: one transfer per cycle
   assign csr_ready = 1'b1;

   // Decode the write; unknown indexes drop the data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_WATERING_INTERVAL: cfg_in.watering_interval = csr_wdata;
            REG_PUMP_DURATION:     cfg_in.pump_duration     = csr_wdata;
            REG_LONG_PRESS_TIME:   cfg_in.long_press_time   = csr_wdata[15:0];
            REG_PRESS_LOCKOUT:     cfg_in.press_lockout     = csr_wdata[15:0];
            REG_SAMPLE_PERIOD:     cfg_in.sample_period     = csr_wdata[7:0];
            REG_BLINK_PERIOD:      cfg_in.blink_period      = csr_wdata;
            REG_BLINK_LENGTH:      cfg_in.blink_length      = csr_wdata[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.watering_interval <= WATERING_INTERVAL_RST;
         cfg_ff.pump_duration     <= PUMP_DURATION_RST;
         cfg_ff.long_press_time   <= LONG_PRESS_TIME_RST;
         cfg_ff.press_lockout     <= PRESS_LOCKOUT_RST;
         cfg_ff.sample_period     <= SAMPLE_PERIOD_RST;
         cfg_ff.blink_period      <= BLINK_PERIOD_RST;
         cfg_ff.blink_length      <= BLINK_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : bcps_csr
`default_nettype wire

FILE: design/bcps_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcps_step
// One millisecond tick: button sampling, pump scheduling and LED blinking.
// ----------------------------------------------------------------------------
module bcps_step (
   input  wire bcps_pkg::cfg_type     cfg,
   input  wire bcps_pkg::state_type   state,
   input  wire logic                  button_down,
   output      bcps_pkg::state_type   state_next,
   output      bcps_pkg::result_type  result
);
   import bcps_pkg::*;

   logic [TIME_W-1:0] now_next;
   logic              sample_due;
   logic              lockout_done;
   logic              is_long;
   logic              interval_done;
   logic              duration_done;
   logic              blink_due;
   logic              blink_done;
   logic              interval_fresh;
   logic              pump_fresh;
   logic              led_fresh;
   press_event_type   press_event;
   state_type         nx;

   // Advance the clock first; all tests use the new time
   assign now_next = state.now_ms + 32'd1;

   // Elapsed tests against the marks held at the start of the tick
   assign sample_due    = elapsed(now_next, state.last_sample_time,
                                  {24'd0, cfg.sample_period});
   assign lockout_done  = elapsed(now_next, state.lockout_start_time,
                                  {16'd0, cfg.press_lockout});
   assign is_long       = elapsed(now_next, state.press_start_time,
                                  {16'd0, cfg.long_press_time});
   assign interval_done = elapsed(now_next, state.interval_start_time,
                                  cfg.watering_interval);
   assign duration_done = elapsed(now_next, state.pump_start_time, cfg.pump_duration);
   assign blink_due     = elapsed(now_next, state.blink_cycle_time, cfg.blink_period);
   assign blink_done    = elapsed(now_next, state.blink_on_time,
                                  {16'd0, cfg.blink_length});

   // Apply the tick in order; a mark set this tick reads as zero elapsed
   always_comb begin
      nx             = state;
      nx.now_ms      = now_next;
      press_event    = EV_NONE;
      interval_fresh = 1'b0;
      pump_fresh     = 1'b0;
      led_fresh      = 1'b0;

      // Button sample
      if (sample_due) begin
         if (button_down && !state.timed && lockout_done) begin
            nx.timed            = 1'b1;
            nx.press_start_time = now_next;
         end
         if (!button_down && state.timed) begin
            nx.lockout_start_time = now_next;
            if (is_long) begin
               press_event        = EV_LONG;
               nx.pump_on         = 1'b1;
               nx.pump_start_time = now_next;
               pump_fresh         = 1'b1;
            end else begin
               press_event            = EV_SHORT;
               nx.interval_start_time = now_next;
               interval_fresh         = 1'b1;
               if (!state.auto_mode) begin
                  nx.auto_mode = 1'b1;
               end else begin
                  nx.auto_mode = 1'b0;
                  nx.pump_on   = 1'b0;
               end
            end
            nx.timed = 1'b0;
         end
         nx.last_sample_time = now_next;
      end

      // Automatic start
      if (nx.auto_mode && !nx.pump_on &&
          (interval_fresh ? (cfg.watering_interval == 32'd0) : interval_done)) begin
         nx.pump_on         = 1'b1;
         nx.pump_start_time = now_next;
         pump_fresh         = 1'b1;
      end

      // Pump stop
      if (nx.pump_on &&
          (pump_fresh ? (cfg.pump_duration == 32'd0) : duration_done)) begin
         nx.pump_on             = 1'b0;
         nx.interval_start_time = now_next;
      end

      // Blink start
      if (nx.auto_mode && blink_due) begin
         nx.led_on           = 1'b1;
         nx.blink_on_time    = now_next;
         nx.blink_cycle_time = now_next;
         led_fresh           = 1'b1;
      end

      // Blink end
      if (nx.led_on && (led_fresh ? (cfg.blink_length == 16'd0) : blink_done)) begin
         nx.led_on = 1'b0;
      end
   end

   assign state_next         = nx;
   assign result.pump_on     = nx.pump_on;
   assign result.led_on      = nx.led_on;
   assign result.auto_mode   = nx.auto_mode;
   assign result.press_event = press_event;

endmodule : bcps_step
`default_nettype wire

FILE: design/button_controlled_pump_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_controlled_pump_scheduler_core
// Millisecond-tick pump scheduler driven by a single push button.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick carrying the button level and
// yields exactly one result transfer with the pump, LED and mode levels and
// the press event. The core takes one tick per clock cycle while results are
// taken; a tick is registered at the input, worked through one pass of
// subtract-and-compare logic against the state registers, and its result is
// held in an output register. A tick passes the input register and then the
// output register before its result is presented. Ticks can follow back to
// back, because the state update for one tick closes in that single pass;
// only a stalled result register holds the input.
// Configuration is taken every cycle on the csr channel and should be
// written only while no tick is in flight.
module button_controlled_pump_scheduler_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Tick input
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [bcps_pkg::TDATA_W-1:0]       req_tdata,  // [0] button_down, [7:1] zero
   // Result output
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [bcps_pkg::TDATA_W-1:0]       rsp_tdata,  // [0] pump_on, [1] led_on,
                                                               // [2] auto_mode,
                                                               // [4:3] press_event, [7:5] zero
   // Configuration writes
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [bcps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bcps_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bcps_pkg::*;

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type step_result;
   result_type rsp_data_ff;
   logic       in_valid_ff;
   logic       in_button_ff;
   logic       rsp_valid_ff;
   logic       advance;

   bcps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcps_step u_step (
      .cfg         (cfg),
      .state       (state_ff),
      .button_down (in_button_ff),
      .state_next  (state_in),
      .result      (step_result)
   );

   // Move the held tick on when the output register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_button_ff <= req_tdata[0];
      end
   end

   // Scheduler state, committed once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff.press_event, rsp_data_ff.auto_mode,
                        rsp_data_ff.led_on, rsp_data_ff.pump_on};

   // Never report the unused event code
   a_event_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.press_event == EV_NONE ||
                        rsp_data_ff.press_event == EV_SHORT ||
                        rsp_data_ff.press_event == EV_LONG))
      else $error("press event code out of range");

   // The time counter moves by exactly one per committed tick
   a_tick_count : assert property (@(posedge clock) disable iff (reset)
      advance |=> (state_ff.now_ms == $past(state_ff.now_ms) + 32'd1))
      else $error("time counter did not advance by one");

   // A reported release always ends the timed press
   a_release_clears : assert property (@(posedge clock) disable iff (reset)
      (advance && step_result.press_event != EV_NONE) |=> !state_ff.timed)
      else $error("press still timed after a release");

   // A short press that leaves automatic mode stops the pump
   a_auto_off_stops : assert property (@(posedge clock) disable iff (reset)
      (advance && step_result.press_event == EV_SHORT && !step_result.auto_mode)
         |-> !step_result.pump_on)
      else $error("pump left running after automatic mode was switched off");

endmodule : button_controlled_pump_scheduler_core
`default_nettype wire
